/* design/positional_sequence_store_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the positional sequence store
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_STORE_UNIT_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pss: same-cycle property violated");

// Next-cycle implication, disabled during reset
`define PSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pss: next-cycle property violated");

`endif

/* design/pss_pkg.sv */
// ----------------------------------------------------------------------------
// Positional sequence store package
// Sizes, command and status codes, and the cell control record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pss_pkg;

  // Store depth and field widths
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;

  // Commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_DUMP   = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Chain operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,
    OP_APPEND,
    OP_DEL,
    OP_ROT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] pos;
  } ctrl_t;

endpackage

/* design/pss_cell.sv */
// ----------------------------------------------------------------------------
// Positional sequence store cell
// One element of the chain; picks its next value from itself, a neighbor or
// the load bus according to the broadcast operation and its own index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pss_cell (
  input  logic                        clk_i,
  input  logic [pss_pkg::IDX_W-1:0]   idx_i,
  input  pss_pkg::ctrl_t              ctrl_i,
  input  logic [pss_pkg::VAL_W-1:0]   left_i,
  input  logic [pss_pkg::VAL_W-1:0]   right_i,
  input  logic [pss_pkg::VAL_W-1:0]   load_i,
  output logic [pss_pkg::VAL_W-1:0]   value_o
);

  logic [pss_pkg::VAL_W-1:0] value_q, value_d;
  logic [pss_pkg::CNT_W-1:0] idx_ext;
  logic [pss_pkg::CNT_W-1:0] idx_nxt;

  assign idx_ext = pss_pkg::CNT_W'(idx_i);
  assign idx_nxt = idx_ext + pss_pkg::CNT_W'(1);

  // Select next value
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      pss_pkg::OP_SHR: begin
        value_d = (idx_ext == '0) ? load_i : left_i;
      end
      pss_pkg::OP_APPEND: begin
        if (idx_ext == ctrl_i.count) value_d = load_i;
      end
      pss_pkg::OP_DEL: begin
        if (idx_ext >= ctrl_i.pos) value_d = right_i;
      end
      pss_pkg::OP_ROT: begin
        if (idx_nxt == ctrl_i.count) begin
          value_d = load_i;
        end else if (idx_nxt < ctrl_i.count) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // Hold element
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

/* design/positional_sequence_store_unit.sv */
// ----------------------------------------------------------------------------
// Positional sequence store unit
// Bounded ordered store of signed 32-bit values kept in a shifting cell chain.
// ----------------------------------------------------------------------------
// Insert, append and delete move every cell of the chain in the same
// cycle, so one request is accepted per cycle as long as no dump is in
// progress and the output register is free or being drained. A dump holds
// the input off from the accepting cycle on: for each element the chain
// rotates its occupied part one place while the head cell feeds the output,
// so input is held off until the last element leaves; an empty dump answers
// with a single result. Stored values have no reset; only occupied cells are
// ever shown.
`timescale 1ns / 1ps

module positional_sequence_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] value, [38:32] position, [39] zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] command
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [31:0] element, [38:32] count, [39] zero
  output logic        m_axis_tlast_o,
  output logic [2:0]  m_axis_tuser_o   // [0] element_valid, [2:1] status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  localparam int VW = pss_pkg::VAL_W;
  localparam int CW = pss_pkg::CNT_W;

  logic                 state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic                 out_valid_q, out_valid_d;
  logic [VW-1:0]        out_elem_q, out_elem_d;
  logic                 out_ev_q, out_ev_d;
  logic                 out_last_q, out_last_d;
  logic [1:0]           out_status_q, out_status_d;
  logic [CW-1:0]        out_count_q, out_count_d;

  logic                 out_free;
  logic                 in_accept;
  logic [VW-1:0]        in_value;
  logic [CW-1:0]        in_pos;
  pss_pkg::ctrl_t       ctrl;
  logic [VW-1:0]        load_val;
  logic [VW-1:0]        cell_val [pss_pkg::CAPACITY];

  assign in_value  = s_axis_tdata_i[31:0];
  assign in_pos    = s_axis_tdata_i[38:32];
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // Decode request and drive the chain
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_elem_d   = out_elem_q;
    out_ev_d     = out_ev_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ctrl.op      = pss_pkg::OP_HOLD;
    ctrl.count   = count_q;
    ctrl.pos     = in_pos - CW'(1);
    load_val     = in_value;

    if (in_accept) begin
      out_valid_d  = 1'b1;
      out_elem_d   = '0;
      out_ev_d     = 1'b0;
      out_last_d   = 1'b1;
      out_status_d = pss_pkg::ST_OK;
      case (s_axis_tuser_i)
        pss_pkg::CMD_INSERT, pss_pkg::CMD_APPEND: begin
          if (count_q == CW'(pss_pkg::CAPACITY)) begin
            out_status_d = pss_pkg::ST_FULL;
          end else begin
            ctrl.op = (s_axis_tuser_i == pss_pkg::CMD_INSERT) ? pss_pkg::OP_SHR
                                                              : pss_pkg::OP_APPEND;
            count_d = count_q + CW'(1);
          end
        end
        pss_pkg::CMD_DELETE: begin
          if (in_pos == '0 || in_pos > count_q) begin
            out_status_d = pss_pkg::ST_RANGE;
          end else begin
            ctrl.op = pss_pkg::OP_DEL;
            count_d = count_q - CW'(1);
          end
        end
        default: begin
          // dump: empty store answers at once, otherwise stream the chain
          if (count_q != '0) begin
            out_valid_d = 1'b0;
            state_d     = ST_DUMP;
            rem_d       = count_q;
          end
        end
      endcase
      out_count_d = count_d;
    end else if (state_q == ST_DUMP && out_free) begin
      // emit head, rotate it to the tail
      ctrl.op      = pss_pkg::OP_ROT;
      load_val     = cell_val[0];
      out_valid_d  = 1'b1;
      out_elem_d   = cell_val[0];
      out_ev_d     = 1'b1;
      out_last_d   = (rem_q == CW'(1));
      out_status_d = pss_pkg::ST_OK;
      out_count_d  = count_q;
      rem_d        = rem_q - CW'(1);
      if (rem_q == CW'(1)) state_d = ST_IDLE;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_elem_q   <= out_elem_d;
    out_ev_q     <= out_ev_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  // Cell chain
  for (genvar i = 0; i < pss_pkg::CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == pss_pkg::CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    pss_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (pss_pkg::IDX_W'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left_v),
      .right_i (right_v),
      .load_i  (load_val),
      .value_o (cell_val[i])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_count_q, out_elem_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_status_q, out_ev_q};

endmodule

/* design/pss_checker.sv */
// ----------------------------------------------------------------------------
// Positional sequence store port checker
// Watches the result channel of the top level and flags impossible results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_sequence_store_unit_macros.svh"

module pss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic [2:0]  m_axis_tuser_o
);

  // stalled result holds its payload
  `PSS_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // only a dump gives more than one result, and those carry elements
  `PSS_ASSERT_IMP(a_multi, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tuser_o[0] && m_axis_tuser_o[2:1] == pss_pkg::ST_OK)

  // a result without an element shows zero
  `PSS_ASSERT_IMP(a_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tdata_o[31:0] == 32'd0)

  // count never exceeds the store depth
  `PSS_ASSERT_IMP(a_count, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[38:32] <= 7'(pss_pkg::CAPACITY))

endmodule

bind positional_sequence_store_unit pss_checker u_pss_checker (.*);
